FILE: design/ttbl_pkg.sv
// Package for the timing table lookup: shared widths, opcodes and the
// axis-search result type. No dependencies.
package ttbl_pkg;

   localparam int VAL_W   = 24;   // axis points, table entries, results
   localparam int CNT_W   = 4;    // axis count field
   localparam int IDX_W   = 4;    // axis index, holds up to 16 points
   localparam int SPAN_W  = 2 * VAL_W;

   localparam logic [2:0] OP_SLEW_AXIS  = 3'd0;
   localparam logic [2:0] OP_LOAD_AXIS  = 3'd1;
   localparam logic [2:0] OP_DELAY_ENT  = 3'd2;
   localparam logic [2:0] OP_TRANS_ENT  = 3'd3;
   localparam logic [2:0] OP_SIZES      = 3'd4;
   localparam logic [2:0] OP_LOOKUP     = 3'd5;

   // Bracket found on one axis: indices, weights and span.
   typedef struct packed {
      logic [IDX_W-1:0] idx_lo;
      logic [IDX_W-1:0] idx_hi;
      logic [VAL_W-1:0] w_lo;
      logic [VAL_W-1:0] w_hi;
      logic [VAL_W-1:0] span;
   } ax_res_type;

endpackage

FILE: design/timing_table_bilinear_lookup.sv
// Top level: table stores, per-gate axis counts and lookup sequencer.
// Depends on ttbl_pkg, ttbl_axis and ttbl_interp.
//
//   channel | direction | beat
//   req_    | in        | opcode, gate, row, col, value, counts, slew_in, load_in
//   rsp_    | out       | delay_out, slew_out, found (lookups only)
//
// Load beats are written into the stores when accepted. A lookup of a present gate holds
// the input while the axis scans read one point a cycle, four corner
// reads follow, then a nine-step multiply-accumulate and the radix-2 divider.
// A lookup of an absent gate goes from the count read straight to the output state.
// Synchronous reset marks all gates absent; table contents stay undefined.
// A finished result waits in the output register while load beats go on; the
// next lookup stalls in its output state until that result is taken.
module timing_table_bilinear_lookup import ttbl_pkg::*; #(
   parameter int GATE_TYPES  = 16,
   parameter int AXIS_POINTS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_opcode,
   input  logic [3:0]       req_gate,
   input  logic [2:0]       req_row,
   input  logic [2:0]       req_col,
   input  logic [VAL_W-1:0] req_value,
   input  logic [CNT_W-1:0] req_slew_count,
   input  logic [CNT_W-1:0] req_load_count,
   input  logic [VAL_W-1:0] req_slew_in,
   input  logic [VAL_W-1:0] req_load_in,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [VAL_W-1:0] rsp_delay_out,
   output logic [VAL_W-1:0] rsp_slew_out,
   output logic             rsp_found
);

   localparam int TDEPTH  = GATE_TYPES * AXIS_POINTS * AXIS_POINTS;
   localparam int TADDR_W = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
   localparam int GIDX_W  = (GATE_TYPES > 1) ? $clog2(GATE_TYPES) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SZ   = 3'd1;
   localparam logic [2:0] S_AX   = 3'd2;
   localparam logic [2:0] S_CR   = 3'd3;
   localparam logic [2:0] S_IP   = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]        state_ff;
   logic              accept;
   logic              gate_ok;
   logic              row_ok;
   logic              col_ok;
   logic [GIDX_W-1:0] gidx;
   logic [CNT_W-1:0]  sc_sat;
   logic [CNT_W-1:0]  lc_sat;

   logic [2*CNT_W-1:0] sizes_mem [GATE_TYPES];
   logic [2*CNT_W-1:0] sz_rd_ff;
   logic [GATE_TYPES-1:0] sz_valid_ff;

   logic [VAL_W-1:0]   dly_mem [TDEPTH];
   logic [VAL_W-1:0]   trn_mem [TDEPTH];
   logic [VAL_W-1:0]   dly_rd_ff;
   logic [VAL_W-1:0]   trn_rd_ff;
   logic [TADDR_W-1:0] t_wr_addr;
   logic [TADDR_W-1:0] t_rd_addr;

   logic [3:0]       gate_ff;
   logic [VAL_W-1:0] slew_in_ff;
   logic [VAL_W-1:0] load_in_ff;
   logic             lookup_ok;
   logic             ax_start;
   logic             sl_done;
   logic             ld_done;
   logic             sl_seen_ff;
   logic             ld_seen_ff;
   ax_res_type       sl_res;
   ax_res_type       ld_res;
   ax_res_type       sl_res_ff;
   ax_res_type       ld_res_ff;
   logic [SPAN_W-1:0] d_ff;
   logic [2:0]       cr_ff;
   logic [IDX_W-1:0] cr_row;
   logic [IDX_W-1:0] cr_col;
   logic [VAL_W-1:0] dly_v_ff [4];
   logic [VAL_W-1:0] trn_v_ff [4];
   logic             ip_start;
   logic             dly_done;
   logic             trn_done;
   logic [VAL_W-1:0] dly_q;
   logic [VAL_W-1:0] trn_q;
   logic [VAL_W-1:0] res_delay_ff;
   logic [VAL_W-1:0] res_slew_ff;
   logic             res_found_ff;
   logic             rsp_valid_ff;
   logic [VAL_W-1:0] rsp_delay_ff;
   logic [VAL_W-1:0] rsp_slew_ff;
   logic             rsp_found_ff;

   function automatic logic [TADDR_W-1:0] tab_addr(input logic [3:0] g,
                                                    input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
      tab_addr = TADDR_W'((int'(g) * AXIS_POINTS + int'(r)) * AXIS_POINTS + int'(c));
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign gate_ok   = int'(req_gate) < GATE_TYPES;
   assign row_ok    = int'(req_row) < AXIS_POINTS;
   assign col_ok    = int'(req_col) < AXIS_POINTS;
   assign gidx      = GIDX_W'(req_gate);
   assign sc_sat    = (int'(req_slew_count) > AXIS_POINTS) ? CNT_W'(AXIS_POINTS)
                                                           : req_slew_count;
   assign lc_sat    = (int'(req_load_count) > AXIS_POINTS) ? CNT_W'(AXIS_POINTS)
                                                           : req_load_count;

   // Axis counts: valid bit per gate, count memory behind it.
   always_ff @(posedge clock) begin
      if (accept && req_opcode == OP_SIZES && gate_ok) begin
         sizes_mem[gidx] <= {lc_sat, sc_sat};
      end
      sz_rd_ff <= sizes_mem[gidx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sz_valid_ff <= '0;
      end else if (accept && req_opcode == OP_SIZES && gate_ok) begin
         sz_valid_ff[gidx] <= 1'b1;
      end
   end

   assign lookup_ok = (int'(gate_ff) < GATE_TYPES) && sz_valid_ff[GIDX_W'(gate_ff)]
                      && sz_rd_ff[CNT_W-1:0] != '0 && sz_rd_ff[2*CNT_W-1:CNT_W] != '0;

   // Corner order: (lo,lo) (lo,hi) (hi,lo) (hi,hi)
   assign cr_row    = cr_ff[1] ? sl_res_ff.idx_hi : sl_res_ff.idx_lo;
   assign cr_col    = cr_ff[0] ? ld_res_ff.idx_hi : ld_res_ff.idx_lo;
   assign t_wr_addr = tab_addr(req_gate, {1'b0, req_row}, {1'b0, req_col});
   assign t_rd_addr = tab_addr(gate_ff, cr_row, cr_col);

   always_ff @(posedge clock) begin
      if (accept && gate_ok && row_ok && col_ok && req_opcode == OP_DELAY_ENT) begin
         dly_mem[t_wr_addr] <= req_value;
      end
      if (accept && gate_ok && row_ok && col_ok && req_opcode == OP_TRANS_ENT) begin
         trn_mem[t_wr_addr] <= req_value;
      end
      dly_rd_ff <= dly_mem[t_rd_addr];
      trn_rd_ff <= trn_mem[t_rd_addr];
   end

   assign ax_start = (state_ff == S_SZ) && lookup_ok;

   ttbl_axis #(.GATE_TYPES(GATE_TYPES), .AXIS_POINTS(AXIS_POINTS)) u_slew_axis (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && req_opcode == OP_SLEW_AXIS && gate_ok && row_ok),
      .wr_gate (req_gate),
      .wr_idx  ({1'b0, req_row}),
      .wr_data (req_value),
      .start   (ax_start),
      .gate    (gate_ff),
      .count   (sz_rd_ff[CNT_W-1:0]),
      .x       (slew_in_ff),
      .done    (sl_done),
      .res     (sl_res)
   );

   ttbl_axis #(.GATE_TYPES(GATE_TYPES), .AXIS_POINTS(AXIS_POINTS)) u_load_axis (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && req_opcode == OP_LOAD_AXIS && gate_ok && col_ok),
      .wr_gate (req_gate),
      .wr_idx  ({1'b0, req_col}),
      .wr_data (req_value),
      .start   (ax_start),
      .gate    (gate_ff),
      .count   (sz_rd_ff[2*CNT_W-1:CNT_W]),
      .x       (load_in_ff),
      .done    (ld_done),
      .res     (ld_res)
   );

   assign ip_start = (state_ff == S_CR) && cr_ff == 3'd4;

   ttbl_interp u_dly_interp (
      .clock   (clock),
      .reset   (reset),
      .start   (ip_start),
      .v11     (dly_v_ff[0]),
      .v12     (dly_v_ff[1]),
      .v21     (dly_v_ff[2]),
      .v22     (dly_v_ff[3]),
      .wt1     (sl_res_ff.w_lo),
      .wt2     (sl_res_ff.w_hi),
      .wc1     (ld_res_ff.w_lo),
      .wc2     (ld_res_ff.w_hi),
      .divisor (d_ff),
      .done    (dly_done),
      .quot    (dly_q)
   );

   ttbl_interp u_trn_interp (
      .clock   (clock),
      .reset   (reset),
      .start   (ip_start),
      .v11     (trn_v_ff[0]),
      .v12     (trn_v_ff[1]),
      .v21     (trn_v_ff[2]),
      .v22     (trn_v_ff[3]),
      .wt1     (sl_res_ff.w_lo),
      .wt2     (sl_res_ff.w_hi),
      .wc1     (ld_res_ff.w_lo),
      .wc2     (ld_res_ff.w_hi),
      .divisor (d_ff),
      .done    (trn_done),
      .quot    (trn_q)
   );

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sl_seen_ff   <= 1'b0;
         ld_seen_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept && req_opcode == OP_LOOKUP) begin
                  state_ff <= S_SZ;
               end
            end
            S_SZ: begin
               sl_seen_ff <= 1'b0;
               ld_seen_ff <= 1'b0;
               state_ff   <= lookup_ok ? S_AX : S_OUT;
            end
            S_AX: begin
               if (sl_done) sl_seen_ff <= 1'b1;
               if (ld_done) ld_seen_ff <= 1'b1;
               if ((sl_done || sl_seen_ff) && (ld_done || ld_seen_ff)) begin
                  state_ff <= S_CR;
               end
            end
            S_CR: if (cr_ff == 3'd4) state_ff <= S_IP;
            S_IP: if (dly_done) state_ff <= S_OUT;
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            gate_ff    <= req_gate;
            slew_in_ff <= req_slew_in;
            load_in_ff <= req_load_in;
         end
         S_SZ: begin
            res_delay_ff <= '0;
            res_slew_ff  <= slew_in_ff;
            res_found_ff <= 1'b0;
         end
         S_AX: begin
            if (sl_done) sl_res_ff <= sl_res;
            if (ld_done) ld_res_ff <= ld_res;
            cr_ff <= '0;
         end
         S_CR: begin
            if (cr_ff == 3'd0) begin
               d_ff <= SPAN_W'(sl_res_ff.span * ld_res_ff.span);
            end
            // read issued in the previous cycle lands now
            if (cr_ff != 3'd0) begin
               dly_v_ff[2'(cr_ff - 3'd1)] <= dly_rd_ff;
               trn_v_ff[2'(cr_ff - 3'd1)] <= trn_rd_ff;
            end
            cr_ff <= cr_ff + 3'd1;
         end
         S_IP: begin
            if (dly_done) begin
               res_delay_ff <= dly_q;
               res_slew_ff  <= trn_q;
               res_found_ff <= 1'b1;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_delay_ff <= res_delay_ff;
               rsp_slew_ff  <= res_slew_ff;
               rsp_found_ff <= res_found_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_delay_out = rsp_delay_ff;
   assign rsp_slew_out  = rsp_slew_ff;
   assign rsp_found     = rsp_found_ff;

   a_fallback_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_delay_out == '0)
      else $error("fallback result with nonzero delay");

   a_axis_done_in_ax: assert property (@(posedge clock) disable iff (reset)
      (sl_done || ld_done) |-> state_ff == S_AX)
      else $error("axis search finished outside axis phase");

   a_interp_lockstep: assert property (@(posedge clock) disable iff (reset)
      dly_done == trn_done)
      else $error("delay and slew interpolators out of step");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT))
      else $error("result loaded outside output state");

endmodule

FILE: design/ttbl_axis.sv
// One axis store (all gates) with its sequential bracket search.
// Depends on ttbl_pkg.
module ttbl_axis import ttbl_pkg::*; #(
   parameter int GATE_TYPES  = 16,
   parameter int AXIS_POINTS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [3:0]       wr_gate,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [VAL_W-1:0] wr_data,
   input  logic             start,
   input  logic [3:0]       gate,
   input  logic [CNT_W-1:0] count,
   input  logic [VAL_W-1:0] x,
   output logic             done,
   output ax_res_type       res
);

   localparam int DEPTH   = GATE_TYPES * AXIS_POINTS;
   localparam int AADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FIRST = 2'd1;
   localparam logic [1:0] S_LAST  = 2'd2;
   localparam logic [1:0] S_SCAN  = 2'd3;

   logic [VAL_W-1:0]   mem [DEPTH];
   logic [VAL_W-1:0]   rd_data_ff;
   logic [AADDR_W-1:0] rd_addr;
   logic [AADDR_W-1:0] wr_addr;

   logic [1:0]       st_ff;
   logic [IDX_W-1:0] k_ff;
   logic [IDX_W-1:0] last_ff;
   logic [3:0]       gate_ff;
   logic [VAL_W-1:0] x_ff;
   logic [VAL_W-1:0] a0_ff;
   logic [VAL_W-1:0] prev_ff;
   logic             done_ff;
   ax_res_type       res_ff;

   function automatic logic [AADDR_W-1:0] ax_addr(input logic [3:0] g,
                                                   input logic [IDX_W-1:0] i);
      ax_addr = AADDR_W'(int'(g) * AXIS_POINTS + int'(i));
   endfunction

   assign wr_addr = ax_addr(wr_gate, wr_idx);

   always_comb begin
      case (st_ff)
         S_IDLE:  rd_addr = ax_addr(gate, '0);
         S_FIRST: rd_addr = ax_addr(gate_ff, last_ff);
         S_LAST:  rd_addr = ax_addr(gate_ff, IDX_W'(1));
         S_SCAN:  rd_addr = ax_addr(gate_ff, k_ff + IDX_W'(1));
         default: rd_addr = ax_addr(gate_ff, '0);
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (st_ff)
            S_IDLE: begin
               if (start) begin
                  st_ff <= S_FIRST;
               end
            end
            S_FIRST: st_ff <= S_LAST;
            S_LAST: begin
               if (x_ff <= a0_ff || x_ff >= rd_data_ff) begin
                  done_ff <= 1'b1;
                  st_ff   <= S_IDLE;
               end else begin
                  st_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (rd_data_ff > x_ff) begin
                  done_ff <= 1'b1;
                  st_ff   <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   // Clamped ends give weights 1/0 over a unit span.
   always_ff @(posedge clock) begin
      case (st_ff)
         S_IDLE: begin
            gate_ff <= gate;
            x_ff    <= x;
            last_ff <= IDX_W'(count - CNT_W'(1));
         end
         S_FIRST: a0_ff <= rd_data_ff;
         S_LAST: begin
            prev_ff <= a0_ff;
            k_ff    <= IDX_W'(1);
            res_ff.w_lo <= VAL_W'(1);
            res_ff.w_hi <= '0;
            res_ff.span <= VAL_W'(1);
            if (x_ff <= a0_ff) begin
               res_ff.idx_lo <= '0;
               res_ff.idx_hi <= '0;
            end else begin
               res_ff.idx_lo <= last_ff;
               res_ff.idx_hi <= last_ff;
            end
         end
         S_SCAN: begin
            prev_ff <= rd_data_ff;
            k_ff    <= k_ff + IDX_W'(1);
            res_ff.idx_lo <= k_ff - IDX_W'(1);
            res_ff.idx_hi <= k_ff;
            res_ff.w_lo   <= rd_data_ff - x_ff;
            res_ff.w_hi   <= x_ff - prev_ff;
            res_ff.span   <= rd_data_ff - prev_ff;
         end
         default: ;
      endcase
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

FILE: design/ttbl_interp.sv
// Bilinear weighted sum over four corners on one shared 25x24 multiplier,
// then a radix-2 divide by the span product. Depends on ttbl_pkg.
module ttbl_interp import ttbl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [VAL_W-1:0]  v11,
   input  logic [VAL_W-1:0]  v12,
   input  logic [VAL_W-1:0]  v21,
   input  logic [VAL_W-1:0]  v22,
   input  logic [VAL_W-1:0]  wt1,
   input  logic [VAL_W-1:0]  wt2,
   input  logic [VAL_W-1:0]  wc1,
   input  logic [VAL_W-1:0]  wc2,
   input  logic [SPAN_W-1:0] divisor,
   output logic              done,
   output logic [VAL_W-1:0]  quot
);

   localparam int PROD_W = 2 * VAL_W + 1;
   localparam int NUM_W  = 3 * VAL_W + 2;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MAC  = 2'd1;
   localparam logic [1:0] S_LOAD = 2'd2;
   localparam logic [1:0] S_DIV  = 2'd3;

   logic [1:0]        st_ff;
   logic [3:0]        step_ff;
   logic [4:0]        cnt_ff;
   logic              done_ff;
   logic [VAL_W:0]    mul_a;
   logic [VAL_W-1:0]  mul_b;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] r_ff;
   logic [PROD_W-1:0] r1_ff;
   logic [PROD_W-1:0] r2_ff;
   logic [NUM_W-1:0]  n_ff;
   logic [SPAN_W-1:0] rem_ff;
   logic [VAL_W-1:0]  lo_ff;
   logic [VAL_W-1:0]  q_ff;
   logic [SPAN_W:0]   trial;

   always_comb begin
      case (step_ff)
         4'd0:    begin mul_a = {1'b0, v11};          mul_b = wc1; end
         4'd1:    begin mul_a = {1'b0, v12};          mul_b = wc2; end
         4'd2:    begin mul_a = {1'b0, v21};          mul_b = wc1; end
         4'd3:    begin mul_a = {1'b0, v22};          mul_b = wc2; end
         4'd4:    begin mul_a = {1'b0, r1_ff[VAL_W-1:0]}; mul_b = wt1; end
         4'd5:    begin mul_a = r1_ff[PROD_W-1:VAL_W];    mul_b = wt1; end
         4'd6:    begin mul_a = {1'b0, r2_ff[VAL_W-1:0]}; mul_b = wt2; end
         4'd7:    begin mul_a = r2_ff[PROD_W-1:VAL_W];    mul_b = wt2; end
         default: begin mul_a = '0;                   mul_b = '0;  end
      endcase
   end

   assign trial = {rem_ff, lo_ff[VAL_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (start) st_ff <= S_MAC;
            S_MAC:  if (step_ff == 4'd8) st_ff <= S_LOAD;
            S_LOAD: st_ff <= S_DIV;
            S_DIV: begin
               if (cnt_ff == 5'(VAL_W - 1)) begin
                  done_ff <= 1'b1;
                  st_ff   <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   // Product of step s is folded in at step s+1.
   always_ff @(posedge clock) begin
      case (st_ff)
         S_IDLE: step_ff <= '0;
         S_MAC: begin
            step_ff <= step_ff + 4'd1;
            prod_ff <= PROD_W'(mul_a * mul_b);
            case (step_ff)
               4'd1: r_ff  <= prod_ff;
               4'd2: r1_ff <= r_ff + prod_ff;
               4'd3: r_ff  <= prod_ff;
               4'd4: r2_ff <= r_ff + prod_ff;
               4'd5: n_ff  <= NUM_W'(prod_ff);
               4'd6: n_ff  <= n_ff + NUM_W'({prod_ff, {VAL_W{1'b0}}});
               4'd7: n_ff  <= n_ff + NUM_W'(prod_ff);
               4'd8: n_ff  <= n_ff + NUM_W'({prod_ff, {VAL_W{1'b0}}});
               default: ;
            endcase
         end
         S_LOAD: begin
            // quotient fits 24 bits, so the upper part is already below divisor
            rem_ff <= n_ff[SPAN_W+VAL_W-1:VAL_W];
            lo_ff  <= n_ff[VAL_W-1:0];
            cnt_ff <= '0;
         end
         S_DIV: begin
            cnt_ff <= cnt_ff + 5'd1;
            lo_ff  <= {lo_ff[VAL_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
               rem_ff <= SPAN_W'(trial - {1'b0, divisor});
               q_ff   <= {q_ff[VAL_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[SPAN_W-1:0];
               q_ff   <= {q_ff[VAL_W-2:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

FILE: dv/timing_table_bilinear_lookup_chk.sv
`timescale 1ns / 1ps
// Checker for timing_table_bilinear_lookup: mirrors the table stores, predicts
// each lookup result and compares it with the response beats. Uses ttbl_pkg.
module timing_table_bilinear_lookup_chk import ttbl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [2:0]       req_opcode,
   input  logic [3:0]       req_gate,
   input  logic [2:0]       req_row,
   input  logic [2:0]       req_col,
   input  logic [VAL_W-1:0] req_value,
   input  logic [CNT_W-1:0] req_slew_count,
   input  logic [CNT_W-1:0] req_load_count,
   input  logic [VAL_W-1:0] req_slew_in,
   input  logic [VAL_W-1:0] req_load_in,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [VAL_W-1:0] rsp_delay_out,
   input  logic [VAL_W-1:0] rsp_slew_out,
   input  logic             rsp_found,
   output int               mismatches,
   output int               pending
);

   localparam int NPTS = 8;

   typedef struct packed {
      logic [VAL_W-1:0] delay;
      logic [VAL_W-1:0] slew;
      logic             found;
   } timing_res_type;

   logic [VAL_W-1:0] slew_pts [16][NPTS];
   logic [VAL_W-1:0] load_pts [16][NPTS];
   logic [VAL_W-1:0] delay_tab [16][NPTS][NPTS];
   logic [VAL_W-1:0] trans_tab [16][NPTS][NPTS];
   logic [3:0]       n_slew [16];
   logic [3:0]       n_load [16];
   timing_res_type   lookup_q [$];

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   task automatic find_bracket(input logic [VAL_W-1:0] pts [NPTS], input int n,
                               input logic [VAL_W-1:0] x, output int lo, output int hi,
                               output logic [127:0] w_lo, output logic [127:0] w_hi,
                               output logic [127:0] span);
      int k;
      lo = 0;
      hi = 0;
      if (x <= pts[0]) begin
         lo = 0; hi = 0;
      end else if (x >= pts[n-1]) begin
         lo = n - 1; hi = n - 1;
      end else begin
         for (k = 1; k < n; k++)
            if (pts[k] > x) break;
         if (k >= n) k = n - 1;
         lo = k - 1;
         hi = k;
      end
      if (lo == hi || pts[hi] <= pts[lo]) begin
         hi = lo; w_lo = 1; w_hi = 0; span = 1;
      end else begin
         w_lo = pts[hi] - x;
         w_hi = x - pts[lo];
         span = pts[hi] - pts[lo];
      end
   endtask

   function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] v00,
         input logic [VAL_W-1:0] v01, input logic [VAL_W-1:0] v10,
         input logic [VAL_W-1:0] v11, input logic [127:0] wt1, input logic [127:0] wt2,
         input logic [127:0] dt, input logic [127:0] wc1, input logic [127:0] wc2,
         input logic [127:0] dc);
      logic [127:0] num;
      logic [127:0] q;
      num = (v00 * wc1 + v01 * wc2) * wt1 + (v10 * wc1 + v11 * wc2) * wt2;
      q = num / (dc * dt);
      return q[VAL_W-1:0];
   endfunction

   task automatic predict_lookup(input int g, input logic [VAL_W-1:0] sin,
                                 input logic [VAL_W-1:0] lin);
      int i1, i2, j1, j2;
      logic [127:0] wt1, wt2, dt, wc1, wc2, dc;
      timing_res_type r;
      if (n_slew[g] == 0 || n_load[g] == 0) begin
         r.delay = '0;
         r.slew  = sin;
         r.found = 1'b0;
      end else begin
         find_bracket(slew_pts[g], n_slew[g], sin, i1, i2, wt1, wt2, dt);
         find_bracket(load_pts[g], n_load[g], lin, j1, j2, wc1, wc2, dc);
         r.delay = blend(delay_tab[g][i1][j1], delay_tab[g][i1][j2], delay_tab[g][i2][j1],
                         delay_tab[g][i2][j2], wt1, wt2, dt, wc1, wc2, dc);
         r.slew  = blend(trans_tab[g][i1][j1], trans_tab[g][i1][j2], trans_tab[g][i2][j1],
                         trans_tab[g][i2][j2], wt1, wt2, dt, wc1, wc2, dc);
         r.found = 1'b1;
      end
      lookup_q.push_back(r);
   endtask

   always @(posedge clock) begin
      timing_res_type want;
      if (reset) begin
         for (int g = 0; g < 16; g++) begin
            n_slew[g] = 0;
            n_load[g] = 0;
         end
      end else begin
         if (req_valid && req_ready) begin
            case (req_opcode)
               OP_SLEW_AXIS: slew_pts[req_gate][req_row] = req_value;
               OP_LOAD_AXIS: load_pts[req_gate][req_col] = req_value;
               OP_DELAY_ENT: delay_tab[req_gate][req_row][req_col] = req_value;
               OP_TRANS_ENT: trans_tab[req_gate][req_row][req_col] = req_value;
               OP_SIZES: begin
                  n_slew[req_gate] = (req_slew_count > NPTS) ? 4'(NPTS) : req_slew_count;
                  n_load[req_gate] = (req_load_count > NPTS) ? 4'(NPTS) : req_load_count;
               end
               OP_LOOKUP: predict_lookup(req_gate, req_slew_in, req_load_in);
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (lookup_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected result beat delay=%0d slew=%0d found=%0b",
                           $realtime, rsp_delay_out, rsp_slew_out, rsp_found);
               mismatches++;
            end else begin
               want = lookup_q.pop_front();
               if (want.delay !== rsp_delay_out || want.slew !== rsp_slew_out ||
                   want.found !== rsp_found) begin
                  if (mismatches < 10)
                     $display("%0t: lookup mismatch exp d=%0d s=%0d f=%0b got d=%0d s=%0d f=%0b",
                              $realtime, want.delay, want.slew, want.found,
                              rsp_delay_out, rsp_slew_out, rsp_found);
                  mismatches++;
               end
            end
         end
      end
      pending = lookup_q.size();
   end

endmodule

FILE: dv/timing_table_bilinear_lookup_tb.sv
`timescale 1ns / 1ps
// Testbench top for timing_table_bilinear_lookup: generates table loads and
// lookups, applies idle/stall phases and gives the verdict. Uses the checker.
module timing_table_bilinear_lookup_tb import ttbl_pkg::*;;

   localparam int          NPTS      = 8;
   localparam int          LIMIT     = 600000;
   localparam logic [2:0]  OP_SPARE6 = 3'd6;
   localparam logic [2:0]  OP_SPARE7 = 3'd7;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   logic [2:0]       req_opcode = '0;
   logic [3:0]       req_gate = '0;
   logic [2:0]       req_row = '0;
   logic [2:0]       req_col = '0;
   logic [VAL_W-1:0] req_value = '0;
   logic [CNT_W-1:0] req_slew_count = '0;
   logic [CNT_W-1:0] req_load_count = '0;
   logic [VAL_W-1:0] req_slew_in = '0;
   logic [VAL_W-1:0] req_load_in = '0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   logic [VAL_W-1:0] rsp_delay_out;
   logic [VAL_W-1:0] rsp_slew_out;
   logic             rsp_found;
   int               mismatches;
   int               pending;
   int               cycles = 0;
   int               sent = 0;
   int               idle_pct = 0;
   int               stall_pct = 0;

   // what has been loaded, so lookups never touch unwritten entries
   logic [3:0]       n_slew [16];
   logic [3:0]       n_load [16];
   logic [VAL_W-1:0] slew_pts [16][NPTS];
   logic [VAL_W-1:0] load_pts [16][NPTS];
   bit               slew_set [16][NPTS];
   bit               load_set [16][NPTS];
   bit               delay_set [16][NPTS][NPTS];
   bit               trans_set [16][NPTS][NPTS];

   always #2 clock = ~clock;

   timing_table_bilinear_lookup u_dut (.*);

   timing_table_bilinear_lookup_chk u_chk (.*);

   always @(posedge clock) begin
      cycles++;
      rsp_ready <= ($urandom_range(99) >= stall_pct);
      if (cycles > LIMIT) begin
         $display("timing_table_bilinear_lookup_tb: errors");
         $finish;
      end
   end

   // one beat; unused fields carry random noise
   task automatic send(input logic [2:0] op, input logic [3:0] g, input logic [2:0] r,
                       input logic [2:0] c, input logic [VAL_W-1:0] v,
                       input logic [3:0] sc, input logic [3:0] lc,
                       input logic [VAL_W-1:0] si, input logic [VAL_W-1:0] li);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_gate <= g;
      req_row <= r;
      req_col <= c;
      req_value <= v;
      req_slew_count <= sc;
      req_load_count <= lc;
      req_slew_in <= si;
      req_load_in <= li;
      case (op)
         OP_SLEW_AXIS: begin slew_pts[g][r] = v; slew_set[g][r] = 1; end
         OP_LOAD_AXIS: begin load_pts[g][c] = v; load_set[g][c] = 1; end
         OP_DELAY_ENT: delay_set[g][r][c] = 1;
         OP_TRANS_ENT: trans_set[g][r][c] = 1;
         OP_SIZES: begin
            n_slew[g] = (sc > NPTS) ? 4'(NPTS) : sc;
            n_load[g] = (lc > NPTS) ? 4'(NPTS) : lc;
         end
         default: ;
      endcase
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic load_beat(input logic [2:0] op, input logic [3:0] g, input logic [2:0] r,
                            input logic [2:0] c, input logic [VAL_W-1:0] v);
      send(op, g, r, c, v, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic set_sizes(input logic [3:0] g, input logic [3:0] sc, input logic [3:0] lc);
      send(OP_SIZES, g, $urandom, $urandom, $urandom, sc, lc, $urandom, $urandom);
   endtask

   // fill whatever the current counts need: ascending axes, random entries
   task automatic complete_gate(input logic [3:0] g);
      logic [VAL_W-1:0] pt;
      pt = $urandom_range(100000);
      for (int r = 0; r < n_slew[g]; r++) begin
         pt += $urandom_range(1, 2000000);
         if (!slew_set[g][r]) load_beat(OP_SLEW_AXIS, g, r, $urandom, pt);
      end
      pt = $urandom_range(100000);
      for (int c = 0; c < n_load[g]; c++) begin
         pt += $urandom_range(1, 2000000);
         if (!load_set[g][c]) load_beat(OP_LOAD_AXIS, g, $urandom, c, pt);
      end
      for (int r = 0; r < n_slew[g]; r++)
         for (int c = 0; c < n_load[g]; c++) begin
            if (!delay_set[g][r][c]) load_beat(OP_DELAY_ENT, g, r, c, $urandom);
            if (!trans_set[g][r][c]) load_beat(OP_TRANS_ENT, g, r, c, $urandom);
         end
   endtask

   function automatic logic [VAL_W-1:0] pick_x(input logic [VAL_W-1:0] pts [NPTS], input int n);
      logic [VAL_W-1:0] x;
      case ($urandom_range(3))
         0: x = VAL_W'($urandom);
         1: x = $urandom_range(1) ? '1 : '0;
         default: begin
            x = (n == 0) ? VAL_W'($urandom) : pts[$urandom_range(n - 1)];
            x = x + VAL_W'($urandom_range(4000)) - VAL_W'(2000);
         end
      endcase
      return x;
   endfunction

   task automatic lookup(input logic [3:0] g, input logic [VAL_W-1:0] si,
                         input logic [VAL_W-1:0] li);
      complete_gate(g);
      send(OP_LOOKUP, g, $urandom, $urandom, $urandom, $urandom, $urandom, si, li);
   endtask

   task automatic rand_lookup(input logic [3:0] g);
      logic [VAL_W-1:0] si, li;
      complete_gate(g);
      si = pick_x(slew_pts[g], n_slew[g]);
      li = pick_x(load_pts[g], n_load[g]);
      lookup(g, si, li);
   endtask

   initial begin
      bit paused;
      logic [3:0] g;
      paused = 1'b0;
      for (int i = 0; i < 16; i++) begin
         n_slew[i] = 0;
         n_load[i] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: absent gate, 3x3 grid, clamps, exact points, saturated counts
      lookup(4'd5, '1, '1);
      set_sizes(4'd0, 4'd3, 4'd3);
      lookup(4'd0, '0, '0);
      lookup(4'd0, '1, '1);
      lookup(4'd0, slew_pts[0][1], load_pts[0][1]);
      lookup(4'd0, slew_pts[0][1] + 1, load_pts[0][2] - 1);
      load_beat(OP_DELAY_ENT, 4'd0, 3'd1, 3'd1, '1);
      load_beat(OP_TRANS_ENT, 4'd0, 3'd1, 3'd2, '1);
      lookup(4'd0, slew_pts[0][1] + 7, load_pts[0][1] + 3);
      set_sizes(4'd0, 4'd3, 4'd0);
      lookup(4'd0, 24'd1234, 24'd5);
      set_sizes(4'd15, 4'd15, 4'd1);
      complete_gate(4'd15);
      lookup(4'd15, slew_pts[15][6] + 1, 24'd77);
      set_sizes(4'd1, 4'd1, 4'd4);
      complete_gate(4'd1);
      lookup(4'd1, 24'd99, load_pts[1][2] + 5);
      // descending and flat axis segments
      load_beat(OP_LOAD_AXIS, 4'd1, 3'd0, 3'd1, '1);
      load_beat(OP_LOAD_AXIS, 4'd1, 3'd0, 3'd2, load_pts[1][0]);
      lookup(4'd1, 24'd0, load_pts[1][0] + 1);
      send(OP_SPARE6, 4'd0, 3'd7, 3'd7, '1, '1, '1, '1, '1);
      send(OP_SPARE7, 4'd0, 3'd0, 3'd0, '0, '0, '0, '0, '0);
      lookup(4'd0, 24'd1234, 24'd5);

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);

      while (sent < 700) begin
         if (sent < 120)      begin idle_pct = 0;  stall_pct = 0;  end
         else if (sent < 280) begin idle_pct = 71; stall_pct = 0;  end
         else if (sent < 440) begin idle_pct = 0;  stall_pct = 71; end
         else if (sent < 560) begin idle_pct = 17; stall_pct = 17; end
         else                 begin idle_pct = 0;  stall_pct = 0;  end
         if (!paused && sent >= 300) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            wait (pending == 0);
            @(posedge clock);
         end
         g = 4'($urandom);
         case ($urandom_range(19))
            0, 1: begin
               if ($urandom_range(3) == 0) set_sizes(g, $urandom, $urandom);
               else set_sizes(g, $urandom_range(1, 3), $urandom_range(1, 3));
            end
            2, 3, 4:
               load_beat($urandom_range(3), g, $urandom, $urandom, $urandom);
            5:
               send($urandom_range(1) ? OP_SPARE6 : OP_SPARE7, g, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom);
            default:
               rand_lookup(g);
         endcase
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (60) @(posedge clock);
      if (mismatches == 0)
         $display("timing_table_bilinear_lookup_tb: clean");
      else
         $display("timing_table_bilinear_lookup_tb: errors");
      $finish;
   end

endmodule
